// File: hdl/msr_pkg.sv
// Shared types and constants for the multiset rank engine.
`default_nettype none

package msr_pkg;

    // Tuple geometry, fixed by the field widths of the request
    localparam int MAX_LEN    = 4;
    localparam int VALUE_BITS = 8;
    localparam int LANES      = MAX_LEN - 1;
    localparam int CNT_W      = 3;
    localparam int RANK_W     = 28;

    // Alphabet register and binomial argument width
    localparam int ALPHA_W = VALUE_BITS + 1;
    localparam int NW      = VALUE_BITS + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX   = ALPHA_W'(1 << VALUE_BITS);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(256);

    // Multiplicative inverse of 3 modulo 2^32 (exact division by 3)
    localparam logic [31:0] INV3 = 32'hAAAA_AAAB;

    // Register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_ALPHA = '0;

    // Request: one tuple
    typedef struct packed {
        logic [VALUE_BITS-1:0] elem0;
        logic [VALUE_BITS-1:0] elem1;
        logic [VALUE_BITS-1:0] elem2;
        logic [VALUE_BITS-1:0] elem3;
        logic [CNT_W-1:0]      count;
    } t_req;

    // Response: rank and error flag
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              bad_tuple;
    } t_rsp;

    // Stage enables for the binomial unit
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } t_binom_en;

    // Per-request data that rides beside the binomial units
    typedef struct packed {
        logic                  bad;
        logic [LANES-1:0]      active;
        logic [VALUE_BITS-1:0] last_diff;
    } t_side;

endpackage

`default_nettype wire

// File: hdl/multiset_rank.sv
// Top level of the multiset rank engine: checks, binomial lanes, rank sum.
`default_nettype none

// Ranks a sorted tuple of one to four elements among all multisets of the
// same length over an alphabet of alphabet_size symbols (register 0, reset
// 256, values above 256 act as 256). One request can enter every cycle while
// responses are taken, and it passes through one stage of checks and argument
// setup, three stages in each of six binomial units (two per tuple position
// but the last), and one summing stage that is also the output register.
// Every stage advances on its own when the one after it has room, so
// bubbles close up while a response waits to be taken. Unsorted tuples,
// elements at or above the alphabet size and counts outside 1..4 give
// bad_tuple set and rank zero. No state is kept between requests; there is
// no start-up sweep.
module multiset_rank (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_req_valid,
    output logic                                   o_req_ready,
    input  wire msr_pkg::t_req                     i_req,
    // response channel
    output logic                                   o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    output msr_pkg::t_rsp                          o_rsp,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [msr_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [msr_pkg::PDATA_W-1:0]       pwdata,
    output logic      [msr_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int ML  = msr_pkg::MAX_LEN;
    localparam int LN  = msr_pkg::LANES;
    localparam int VB  = msr_pkg::VALUE_BITS;
    localparam int CW  = msr_pkg::CNT_W;
    localparam int NW  = msr_pkg::NW;
    localparam int RW  = msr_pkg::RANK_W;
    localparam int NST = 5;

    // ---------------- configuration ----------------
    logic [msr_pkg::ALPHA_W-1:0] r_alpha;
    logic [msr_pkg::ALPHA_W-1:0] alpha_eff;
    logic                        reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[msr_pkg::PADDR_W-1:2] == msr_pkg::REG_ALPHA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= msr_pkg::ALPHA_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_alpha <= pwdata[msr_pkg::ALPHA_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata[msr_pkg::ALPHA_W-1:0] = r_alpha;
        end
    end

    assign alpha_eff = (r_alpha > msr_pkg::ALPHA_MAX) ? msr_pkg::ALPHA_MAX : r_alpha;

    // ---------------- stage control ----------------
    logic [NST:1] r_vld;
    logic [NST:1] rdy;

    always_comb begin
        rdy[NST] = !r_vld[NST] || i_rsp_ready;
        for (int s = NST - 1; s >= 1; s--) begin
            rdy[s] = !r_vld[s] || rdy[s+1];
        end
    end

    assign o_req_ready = rdy[1];
    assign o_rsp_valid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_req_valid;
            end
            for (int s = 2; s <= NST; s++) begin
                if (rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // ---------------- stage 1: checks and binomial arguments ----------------
    logic [VB-1:0]  e  [ML];
    logic [VB-1:0]  pv [LN];
    logic [CW-1:0]  k;

    assign e[0] = i_req.elem0;
    assign e[1] = i_req.elem1;
    assign e[2] = i_req.elem2;
    assign e[3] = i_req.elem3;
    assign k    = i_req.count;

    // element before each lane's own, zero ahead of the first
    assign pv[0] = '0;
    for (genvar g = 1; g < LN; g++) begin : g_prev
        assign pv[g] = e[g-1];
    end

    msr_pkg::t_side n_side;
    logic [NW-1:0]  n_nhi [LN];
    logic [NW-1:0]  n_nlo [LN];
    logic [CW-1:0]  n_rem [LN];

    always_comb begin
        n_side.bad = (k == '0) || (k > CW'(ML));
        for (int i = 0; i < ML; i++) begin
            if ((CW'(i) < k) && ({1'b0, e[i]} >= alpha_eff)) begin
                n_side.bad = 1'b1;
            end
        end
        for (int i = 1; i < ML; i++) begin
            if ((CW'(i) < k) && (e[i] < e[i-1])) begin
                n_side.bad = 1'b1;
            end
        end

        // lane i counts multisets with a smaller element at position i
        for (int i = 0; i < LN; i++) begin
            n_side.active[i] = (CW'(i + 1) < k);
            n_rem[i] = k - CW'(i);
            n_nhi[i] = NW'(alpha_eff) + NW'(n_rem[i]) - NW'(1) - NW'(pv[i]);
            n_nlo[i] = NW'(alpha_eff) + NW'(n_rem[i]) - NW'(1) - NW'(e[i]);
        end

        // last element, shifted by the one before it
        case (k)
            CW'(1):  n_side.last_diff = e[0];
            CW'(2):  n_side.last_diff = e[1] - e[0];
            CW'(3):  n_side.last_diff = e[2] - e[1];
            CW'(4):  n_side.last_diff = e[3] - e[2];
            default: n_side.last_diff = '0;
        endcase
    end

    msr_pkg::t_side r_side [1:4];
    logic [NW-1:0]  r_nhi  [LN];
    logic [NW-1:0]  r_nlo  [LN];
    logic [CW-1:0]  r_rem  [LN];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_side[1] <= n_side;
            for (int i = 0; i < LN; i++) begin
                r_nhi[i] <= n_nhi[i];
                r_nlo[i] <= n_nlo[i];
                r_rem[i] <= n_rem[i];
            end
        end
        for (int s = 2; s <= 4; s++) begin
            if (rdy[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // ---------------- stages 2..4: binomial lanes ----------------
    msr_pkg::t_binom_en ben;
    logic [RW-1:0]      c_hi [LN];
    logic [RW-1:0]      c_lo [LN];

    assign ben.a = rdy[2];
    assign ben.b = rdy[3];
    assign ben.c = rdy[4];

    for (genvar g = 0; g < LN; g++) begin : g_lane
        msr_binom u_hi (
            .i_clk (i_clk),
            .i_en  (ben),
            .i_n   (r_nhi[g]),
            .i_r   (r_rem[g]),
            .o_val (c_hi[g])
        );
        msr_binom u_lo (
            .i_clk (i_clk),
            .i_en  (ben),
            .i_n   (r_nlo[g]),
            .i_r   (r_rem[g]),
            .o_val (c_lo[g])
        );
    end

    // ---------------- stage 5: rank sum and output register ----------------
    logic [RW-1:0]  rank_sum;
    msr_pkg::t_rsp  n_rsp;
    msr_pkg::t_rsp  r_rsp;

    always_comb begin
        rank_sum = RW'(r_side[4].last_diff);
        for (int i = 0; i < LN; i++) begin
            if (r_side[4].active[i]) begin
                rank_sum = rank_sum + (c_hi[i] - c_lo[i]);
            end
        end
        n_rsp.bad_tuple = r_side[4].bad;
        n_rsp.rank      = r_side[4].bad ? '0 : rank_sum;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NST]) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// File: hdl/msr_binom.sv
// Three-stage pipelined binomial C(n, r) for r in 2..4, n >= r.
`default_nettype none

module msr_binom (
    input  wire logic                          i_clk,
    input  wire msr_pkg::t_binom_en            i_en,
    input  wire logic [msr_pkg::NW-1:0]        i_n,
    input  wire logic [msr_pkg::CNT_W-1:0]     i_r,
    output logic      [msr_pkg::RANK_W-1:0]    o_val
);

    localparam int PW  = 2 * msr_pkg::NW;      // n*(n-1)
    localparam int HW  = PW - 1;               // C(n,2)
    localparam int M3W = HW + msr_pkg::NW;     // C(n,2)*(n-2)
    localparam int M4W = 2 * HW;               // C(n,2)*C(n-2,2)
    localparam int RW  = msr_pkg::RANK_W;

    logic [msr_pkg::NW-1:0] n1, n2, n3;

    logic [PW-1:0]              r_a_nn, r_a_mm;
    logic [msr_pkg::NW-1:0]     r_a_n2;
    logic [msr_pkg::CNT_W-1:0]  r_a_r;

    logic [HW-1:0]              r_b_p2;
    logic [M3W-1:0]             r_b_m3;
    logic [M4W-1:0]             r_b_m4;
    logic [msr_pkg::CNT_W-1:0]  r_b_r;

    logic [HW-1:0]  p2, q2;
    logic [RW-1:0]  c3, c4, n_val;
    logic [RW-1:0]  r_val;

    assign n1 = i_n - msr_pkg::NW'(1);
    assign n2 = i_n - msr_pkg::NW'(2);
    assign n3 = i_n - msr_pkg::NW'(3);

    // Stage a: falling products of two
    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_a_nn <= {{msr_pkg::NW{1'b0}}, i_n} * {{msr_pkg::NW{1'b0}}, n1};
            r_a_mm <= {{msr_pkg::NW{1'b0}}, n2} * {{msr_pkg::NW{1'b0}}, n3};
            r_a_n2 <= n2;
            r_a_r  <= i_r;
        end
    end

    // Stage b: C(n,2), then 3*C(n,3) and 6*C(n,4)
    assign p2 = r_a_nn[PW-1:1];
    assign q2 = r_a_mm[PW-1:1];

    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            r_b_p2 <= p2;
            r_b_m3 <= M3W'(p2) * M3W'(r_a_n2);
            r_b_m4 <= M4W'(p2) * M4W'(q2);
            r_b_r  <= r_a_r;
        end
    end

    // Stage c: exact division by 3 (and by 6) through the modular inverse
    assign c3 = RW'(r_b_m3) * msr_pkg::INV3[RW-1:0];
    assign c4 = r_b_m4[RW:1] * msr_pkg::INV3[RW-1:0];

    always_comb begin
        case (r_b_r)
            msr_pkg::CNT_W'(2): n_val = RW'(r_b_p2);
            msr_pkg::CNT_W'(3): n_val = c3;
            msr_pkg::CNT_W'(4): n_val = c4;
            default:            n_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire
